[hdl/bfa_pkg.sv]
// Shared types, constants and codes for the best-fit block allocator.
package bfa_pkg;

    localparam int MEM_BYTES         = 8192;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int IDX_MAX_W         = 10;
    localparam int SIZE_W            = 14;
    localparam int ADDR_W            = 13;
    localparam int OWNER_W           = 16;
    localparam int GRAN_W            = 9;
    localparam int NEED_W            = 15;

    localparam logic [GRAN_W-1:0] GRAN_RESET = 9'd8;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOMEM   = 2'd1;
    localparam logic [1:0] STAT_BADADDR = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] free_address;
        logic [OWNER_W-1:0] owner_id;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] block_address;
        logic [SIZE_W-1:0] granted_size;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_SCAN,
        S_COMMIT
    } state_t;

    // Read data of one table row, both tables
    typedef struct packed {
        logic              fvalid;
        logic [ADDR_W-1:0] fbase;
        logic [SIZE_W-1:0] fsize;
        logic              avalid;
        logic [ADDR_W-1:0] abase;
        logic [SIZE_W-1:0] agranted;
    } rd_t;

    // Write commands for both tables
    typedef struct packed {
        logic                 f_we;
        logic                 f_vwe;
        logic                 f_vval;
        logic [IDX_MAX_W-1:0] f_idx;
        logic [ADDR_W-1:0]    f_base;
        logic [SIZE_W-1:0]    f_size;
        logic                 a_we;
        logic                 a_vwe;
        logic                 a_vval;
        logic [IDX_MAX_W-1:0] a_idx;
        logic [OWNER_W-1:0]   a_owner;
        logic [ADDR_W-1:0]    a_base;
        logic [SIZE_W-1:0]    a_req;
        logic [SIZE_W-1:0]    a_granted;
    } wr_t;

endpackage

[hdl/bfa_round.sv]
// Size rounding unit: restoring divide by the granule, then multiply back.
module bfa_round (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bfa_pkg::NEED_W-1:0] dividend,
    input  logic [bfa_pkg::GRAN_W-1:0] divisor,
    output logic                       done,
    output logic [bfa_pkg::NEED_W-1:0] need
);
    import bfa_pkg::*;

    logic              busy_reg;
    logic              mul_reg;
    logic              done_reg;
    logic [3:0]        cnt_reg;
    logic [GRAN_W-1:0] rem_reg;
    logic [NEED_W-1:0] quo_reg;
    logic [GRAN_W-1:0] dvs_reg;
    logic [NEED_W-1:0] need_reg;

    logic [GRAN_W:0]   trial;
    logic              ge;
    logic [GRAN_W-1:0] rem_next;
    logic [23:0]       prod;

    // One quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[NEED_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? GRAN_W'(trial - {1'b0, dvs_reg}) : trial[GRAN_W-1:0];
        prod     = {9'd0, quo_reg} * {15'd0, dvs_reg};
    end

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(NEED_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    busy_reg <= 1'b0;
                    mul_reg  <= 1'b1;
                end
            end
            else if (mul_reg)
            begin
                mul_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= (divisor == '0) ? GRAN_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NEED_W-2:0], ge};
        end
        if (mul_reg)
            need_reg <= prod[NEED_W-1:0];
    end

    assign done = done_reg;
    assign need = need_reg;

endmodule

[hdl/bfa_store.sv]
// Free-extent and allocation tables: synchronous memories plus valid bits.
module bfa_store #(
    parameter int TABLE_ENTRIES = bfa_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output bfa_pkg::rd_t     rd,
    input  bfa_pkg::wr_t     wr
);
    import bfa_pkg::*;

    localparam int FW = ADDR_W + SIZE_W;
    localparam int AW = OWNER_W + ADDR_W + SIZE_W + SIZE_W;

    logic [FW-1:0] fmem [TABLE_ENTRIES];
    logic [AW-1:0] amem [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] fvalid_reg;
    logic [TABLE_ENTRIES-1:0] avalid_reg;
    logic                     f0_init_reg;
    logic [FW-1:0]            fdata_reg;
    logic [AW-1:0]            adata_reg;
    logic                     fv_rd_reg;
    logic                     av_rd_reg;
    logic                     init_rd_reg;

    logic [IDX_W-1:0] f_idx;
    logic [IDX_W-1:0] a_idx;

    assign f_idx = wr.f_idx[IDX_W-1:0];
    assign a_idx = wr.a_idx[IDX_W-1:0];

    // Free-extent memory
    always_ff @(posedge clk)
    begin
        if (wr.f_we)
            fmem[f_idx] <= {wr.f_base, wr.f_size};
        if (rd_en)
            fdata_reg <= fmem[rd_idx];
    end

    // Allocation memory
    always_ff @(posedge clk)
    begin
        if (wr.a_we)
            amem[a_idx] <= {wr.a_owner, wr.a_base, wr.a_req, wr.a_granted};
        if (rd_en)
            adata_reg <= amem[rd_idx];
    end

    // Valid bits; entry 0 reads as the whole memory until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvalid_reg  <= TABLE_ENTRIES'(1);
            avalid_reg  <= '0;
            f0_init_reg <= 1'b1;
            fv_rd_reg   <= 1'b0;
            av_rd_reg   <= 1'b0;
            init_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr.f_vwe)
                fvalid_reg[f_idx] <= wr.f_vval;
            if (wr.a_vwe)
                avalid_reg[a_idx] <= wr.a_vval;
            if (wr.f_we && f_idx == '0)
                f0_init_reg <= 1'b0;
            if (rd_en)
            begin
                fv_rd_reg   <= fvalid_reg[rd_idx];
                av_rd_reg   <= avalid_reg[rd_idx];
                init_rd_reg <= f0_init_reg && (rd_idx == '0);
            end
        end
    end

    // Present the row
    always_comb
    begin
        rd.fvalid   = fv_rd_reg;
        rd.fbase    = init_rd_reg ? '0 : fdata_reg[FW-1:SIZE_W];
        rd.fsize    = init_rd_reg ? SIZE_W'(MEM_BYTES) : fdata_reg[SIZE_W-1:0];
        rd.avalid   = av_rd_reg;
        rd.abase    = adata_reg[2*SIZE_W+ADDR_W-1:2*SIZE_W];
        rd.agranted = adata_reg[SIZE_W-1:0];
    end

endmodule

[hdl/best_fit_block_allocator.sv]
// Best-fit block allocator top level: request sequencer, table scan and commit.
//
//   port group          dir   handshake          contents
//   in_valid/in_data    in    valid/ready        req_t request
//   out_valid/out_data  out   valid/ready        rsp_t result
//   cfg_we/cfg_data     in    write enable only  granule register
//
// Allocate: rounding (15 divide steps, one multiply), then a scan over both
// memories at one row a cycle, then a commit. Free skips rounding. A zero-size
// allocate skips rounding and the scan and goes straight to the commit.
// Reset clears valid bits in flip-flops; no clearing pass. A stalled output
// holds the commit until the result register drains; a new request is taken
// while a finished result still waits.
module best_fit_block_allocator #(
    parameter int TABLE_ENTRIES = bfa_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bfa_pkg::req_t              in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bfa_pkg::rsp_t              out_data,
    input  logic                       cfg_we,
    input  logic [bfa_pkg::GRAN_W-1:0] cfg_data
);
    import bfa_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W:0] N_ENT = (IDX_W+1)'(TABLE_ENTRIES);

    state_t            state_reg;
    state_t            state_next;
    req_t              req_reg;
    logic [GRAN_W-1:0] gran_reg;
    logic [IDX_W:0]    scan_cnt_reg;
    logic              eval_vld_reg;
    logic [IDX_W-1:0]  eval_idx_reg;
    logic [NEED_W-1:0] need_reg;
    logic              hit_reg;
    logic              exact_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [ADDR_W-1:0] best_base_reg;
    logic [SIZE_W-1:0] best_size_reg;
    logic              slot_ok_reg;
    logic [IDX_W-1:0]  slot_idx_reg;
    logic              out_valid_reg;
    rsp_t              out_data_reg;

    logic              accept;
    logic              rd_en;
    logic              rnd_start;
    logic              rnd_done;
    logic [NEED_W-1:0] rnd_need;
    logic [NEED_W-1:0] rnd_dividend;
    logic [GRAN_W-1:0] gran_eff;
    logic              commit_fire;
    rd_t               rd;
    wr_t               wr_cmd;
    wr_t               wr;
    rsp_t              rsp;

    assign accept    = in_valid && in_ready;
    assign gran_eff  = (gran_reg == '0) ? GRAN_W'(1) : gran_reg;
    assign rnd_start = accept && (in_data.req_type == REQ_ALLOC)
                       && (in_data.request_size != '0);
    assign rnd_dividend = {1'b0, in_data.request_size} + {6'd0, gran_eff} - NEED_W'(1);

    bfa_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rnd_start),
        .dividend (rnd_dividend),
        .divisor  (gran_eff),
        .done     (rnd_done),
        .need     (rnd_need)
    );

    bfa_store #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (rd_en),
        .rd_idx (scan_cnt_reg[IDX_W-1:0]),
        .rd     (rd),
        .wr     (wr)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.req_type == REQ_FREE)
                        state_next = S_SCAN;
                    else if (in_data.request_size == '0)
                        state_next = S_COMMIT;
                    else
                        state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (rnd_done)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == N_ENT && !eval_vld_reg)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit_fire)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready    = 1'b0;
        rd_en       = 1'b0;
        commit_fire = 1'b0;
        unique case (state_reg)
            S_IDLE:   in_ready = 1'b1;
            S_ROUND:  in_ready = 1'b0;
            S_SCAN:   rd_en = scan_cnt_reg < N_ENT;
            S_COMMIT: commit_fire = !out_valid_reg || out_ready;
            default:  in_ready = 1'b0;
        endcase
    end

    // Build the result and table updates from the scan outcome
    always_comb
    begin
        rsp    = '0;
        wr_cmd = '0;
        if (req_reg.req_type == REQ_ALLOC)
        begin
            if (!hit_reg)
                rsp.status = STAT_NOMEM;
            else if (!slot_ok_reg)
                rsp.status = STAT_FULL;
            else
            begin
                rsp.status        = STAT_OK;
                rsp.block_address = best_base_reg;
                rsp.granted_size  = need_reg[SIZE_W-1:0];
                wr_cmd.a_we       = 1'b1;
                wr_cmd.a_vwe      = 1'b1;
                wr_cmd.a_vval     = 1'b1;
                wr_cmd.a_idx      = IDX_MAX_W'(slot_idx_reg);
                wr_cmd.a_owner    = req_reg.owner_id;
                wr_cmd.a_base     = best_base_reg;
                wr_cmd.a_req      = req_reg.request_size;
                wr_cmd.a_granted  = need_reg[SIZE_W-1:0];
                wr_cmd.f_idx      = IDX_MAX_W'(best_idx_reg);
                if ({1'b0, best_size_reg} == need_reg)
                begin
                    wr_cmd.f_vwe  = 1'b1;
                    wr_cmd.f_vval = 1'b0;
                end
                else
                begin
                    wr_cmd.f_we   = 1'b1;
                    wr_cmd.f_base = best_base_reg + need_reg[ADDR_W-1:0];
                    wr_cmd.f_size = best_size_reg - need_reg[SIZE_W-1:0];
                end
            end
        end
        else
        begin
            if (!hit_reg)
                rsp.status = STAT_BADADDR;
            else if (!slot_ok_reg)
                rsp.status = STAT_FULL;
            else
            begin
                rsp.status        = STAT_OK;
                rsp.block_address = best_base_reg;
                rsp.granted_size  = best_size_reg;
                wr_cmd.f_we       = 1'b1;
                wr_cmd.f_vwe      = 1'b1;
                wr_cmd.f_vval     = 1'b1;
                wr_cmd.f_idx      = IDX_MAX_W'(slot_idx_reg);
                wr_cmd.f_base     = best_base_reg;
                wr_cmd.f_size     = best_size_reg;
                wr_cmd.a_vwe      = 1'b1;
                wr_cmd.a_vval     = 1'b0;
                wr_cmd.a_idx      = IDX_MAX_W'(best_idx_reg);
            end
        end
        wr = commit_fire ? wr_cmd : '0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gran_reg      <= GRAN_RESET;
            scan_cnt_reg  <= '0;
            eval_vld_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            exact_reg     <= 1'b0;
            slot_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            eval_vld_reg <= rd_en;
            if (cfg_we)
                gran_reg <= cfg_data;
            if (accept)
            begin
                scan_cnt_reg <= '0;
                hit_reg      <= 1'b0;
                exact_reg    <= 1'b0;
                slot_ok_reg  <= 1'b0;
            end
            else
            begin
                if (rd_en)
                    scan_cnt_reg <= scan_cnt_reg + (IDX_W+1)'(1);
                // Evaluate the row read in the previous cycle
                if (eval_vld_reg)
                begin
                    if (req_reg.req_type == REQ_ALLOC)
                    begin
                        if (!exact_reg && rd.fvalid)
                        begin
                            if ({1'b0, rd.fsize} == need_reg)
                            begin
                                hit_reg   <= 1'b1;
                                exact_reg <= 1'b1;
                            end
                            else if ({1'b0, rd.fsize} > need_reg
                                     && (!hit_reg || rd.fsize < best_size_reg))
                                hit_reg <= 1'b1;
                        end
                        if (!slot_ok_reg && !rd.avalid)
                            slot_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        if (!hit_reg && rd.avalid && rd.abase == req_reg.free_address)
                            hit_reg <= 1'b1;
                        if (!slot_ok_reg && !rd.fvalid)
                            slot_ok_reg <= 1'b1;
                    end
                end
            end
            if (commit_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= in_data;
        if (rnd_done)
            need_reg <= rnd_need;
        if (commit_fire)
            out_data_reg <= rsp;
        if (eval_vld_reg)
        begin
            if (req_reg.req_type == REQ_ALLOC)
            begin
                if (!exact_reg && rd.fvalid
                    && (({1'b0, rd.fsize} == need_reg)
                        || ({1'b0, rd.fsize} > need_reg
                            && (!hit_reg || rd.fsize < best_size_reg))))
                begin
                    best_idx_reg  <= eval_idx_reg;
                    best_base_reg <= rd.fbase;
                    best_size_reg <= rd.fsize;
                end
                if (!slot_ok_reg && !rd.avalid)
                    slot_idx_reg <= eval_idx_reg;
            end
            else
            begin
                if (!hit_reg && rd.avalid && rd.abase == req_reg.free_address)
                begin
                    best_idx_reg  <= eval_idx_reg;
                    best_base_reg <= rd.abase;
                    best_size_reg <= rd.agranted;
                end
                if (!slot_ok_reg && !rd.fvalid)
                    slot_idx_reg <= eval_idx_reg;
            end
        end
        if (rd_en)
            eval_idx_reg <= scan_cnt_reg[IDX_W-1:0];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Row evaluation only follows a read issued by the scan
    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        eval_vld_reg |-> state_reg == S_SCAN)
        else $error("row evaluated outside scan");

    // Rounding completes only while waiting for it
    a_round_done: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_done |-> state_reg == S_ROUND)
        else $error("rounding done outside round state");

    // A new result only ever comes from a commit
    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_COMMIT))
        else $error("result raised without commit");

    // Scan counter never passes the table depth
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= N_ENT)
        else $error("scan counter past table depth");

    // Table writes happen only on a commit transfer
    a_wr_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.f_we || wr.f_vwe || wr.a_we || wr.a_vwe) |-> state_reg == S_COMMIT)
        else $error("table write outside commit");

endmodule
